// ----- src/context_map_mtf_decode_check_defines.svh -----
// Assertion macros shared by the checker.
`ifndef CONTEXT_MAP_MTF_DECODE_CHECK_DEFINES_SVH
`define CONTEXT_MAP_MTF_DECODE_CHECK_DEFINES_SVH

// Clocked assertion, disabled while reset is held.
`define CMMTF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication between two conditions on the same clocking.
`define CMMTF_ASSERT_IMPL(label, pre, post, msg) \
  `CMMTF_ASSERT(label, (pre) |-> (post), msg)

// Implication with the consequence in the next cycle.
`define CMMTF_ASSERT_NEXT(label, pre, post, msg) \
  `CMMTF_ASSERT(label, (pre) |=> (post), msg)

`endif

// ----- src/cmmtf_pkg.sv -----
`timescale 1ns / 1ps

package cmmtf_pkg;

  // Move-to-front table depth and field widths
  localparam int TABLE_SIZE   = 256;
  localparam int SYM_W        = 8;
  localparam int CNT_W        = 9;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_PAD_W    = OUT_TDATA_W - SYM_W - CNT_W - 1;

  // Broadcast to every table cell
  typedef struct packed {
    logic             upd;     // item accepted this cycle
    logic             mtf_en;  // move-to-front mode
    logic             clr;     // return to the reset image
    logic [SYM_W-1:0] sym;     // saturated symbol
  } cmmtf_ctrl_t;

  // One result item
  typedef struct packed {
    logic             map_complete;
    logic [CNT_W-1:0] num_clusters;
    logic             is_last;
    logic [SYM_W-1:0] cluster_id;
  } cmmtf_result_t;

endpackage

// ----- src/context_map_mtf_decode_check.sv -----
`timescale 1ns / 1ps

// Channel   | Direction | tdata (low bit up)                         | tlast
// ----------+-----------+--------------------------------------------+-----------
// s_axis    | in        | symbol[7:0]                                | last_entry
// m_axis    | out       | cluster_id[7:0], num_clusters[16:8],       | is_last
//           |           | map_complete[17], zero pad[23:18]          |
// cfg       | in        | cfg_wdata_i = use_mtf (written on cfg_we_i) | -
//
// The accept cycle of an item looks up and, in MTF mode, shifts the
// move-to-front cell row; then the completeness chain runs over all cells
// and loads the output register once it is free. tready is low in the cycle
// after accept and stays low while the output register is full and not taken.
// Reset restores the identity table, clears all presence flags and the
// maximum at once; the last entry of a map does the same as its result
// is loaded. No clearing pass is needed.
module context_map_mtf_decode_check #(
  parameter int TABLE_SIZE = cmmtf_pkg::TABLE_SIZE
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cmmtf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // symbol[7:0]
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // cluster_id[7:0], num_clusters[16:8], map_complete[17], pad[23:18]
  output logic [cmmtf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int SW = cmmtf_pkg::SYM_W;
  localparam int CW = cmmtf_pkg::CNT_W;

  logic                    use_mtf_q;
  logic                    busy_q;
  logic [SW-1:0]           pend_id_q;
  logic                    pend_last_q;
  logic [SW-1:0]           max_q;
  logic                    accept;
  logic                    load;
  logic                    out_free;
  logic [SW-1:0]           sym_sat;
  logic [SW-1:0]           lookup;
  logic [SW-1:0]           id;
  cmmtf_pkg::cmmtf_ctrl_t  ctrl;
  cmmtf_pkg::cmmtf_result_t res;

  logic [SW-1:0] val_w  [TABLE_SIZE];
  logic [SW-1:0] rd_w   [TABLE_SIZE];
  logic [SW-1:0] prev_w [TABLE_SIZE];
  logic          ok_w   [TABLE_SIZE+1];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_mtf_q <= 1'b1;
    end else if (cfg_we_i) begin
      use_mtf_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = ~busy_q;
  assign accept        = s_axis_tvalid & ~busy_q;
  assign load          = busy_q & out_free;

  // Saturate the symbol to the table
  assign sym_sat = ({1'b0, s_axis_tdata[SW-1:0]} > CW'(TABLE_SIZE - 1))
                   ? SW'(TABLE_SIZE - 1) : s_axis_tdata[SW-1:0];

  // Gather the addressed entry from the cell row
  always_comb begin
    lookup = '0;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      lookup = lookup | rd_w[k];
    end
  end

  assign id = use_mtf_q ? lookup : sym_sat;

  assign ctrl.upd    = accept;
  assign ctrl.mtf_en = use_mtf_q;
  assign ctrl.clr    = load & pend_last_q;
  assign ctrl.sym    = sym_sat;

  // Cell row: in MTF mode, cells up to the chosen index shift in their left neighbor; cell 0 takes the id
  assign ok_w[0] = 1'b1;
  for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev_w[k] = id;
    end else begin : g_body
      assign prev_w[k] = val_w[k-1];
    end
    cmmtf_cell #(
      .IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .id_i       (id),
      .max_i      (max_q),
      .prev_val_i (prev_w[k]),
      .ok_i       (ok_w[k]),
      .val_o      (val_w[k]),
      .rd_o       (rd_w[k]),
      .ok_o       (ok_w[k+1])
    );
  end

  // Sequencing and running maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      max_q       <= '0;
      pend_last_q <= 1'b0;
    end else if (accept) begin
      busy_q      <= 1'b1;
      pend_last_q <= s_axis_tlast;
      if (id > max_q) begin
        max_q <= id;
      end
    end else if (load) begin
      busy_q <= 1'b0;
      if (pend_last_q) begin
        max_q <= '0;
      end
    end
  end

  // Hold the decoded id for the result cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_id_q <= id;
    end
  end

  assign res.cluster_id   = pend_id_q;
  assign res.is_last      = pend_last_q;
  assign res.num_clusters = pend_last_q ? ({1'b0, max_q} + CW'(1)) : '0;
  assign res.map_complete = pend_last_q & ok_w[TABLE_SIZE];

  cmmtf_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- src/cmmtf_cell.sv -----
`timescale 1ns / 1ps

// One table position: holds the MTF entry at position IDX and the
// presence flag of cluster id IDX.
module cmmtf_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cmmtf_pkg::cmmtf_ctrl_t           ctrl_i,
  input  logic [cmmtf_pkg::SYM_W-1:0]      id_i,
  input  logic [cmmtf_pkg::SYM_W-1:0]      max_i,
  input  logic [cmmtf_pkg::SYM_W-1:0]      prev_val_i,
  input  logic                             ok_i,
  output logic [cmmtf_pkg::SYM_W-1:0]      val_o,
  output logic [cmmtf_pkg::SYM_W-1:0]      rd_o,
  output logic                             ok_o
);

  logic [cmmtf_pkg::SYM_W-1:0] val_q, val_d;
  logic                        seen_q, seen_d;
  logic                        shift;

  // Take the neighbor's entry when the chosen index is at or past this cell
  assign shift = ctrl_i.upd & ctrl_i.mtf_en & (cmmtf_pkg::SYM_W'(IDX) <= ctrl_i.sym);

  always_comb begin
    val_d  = val_q;
    seen_d = seen_q;
    if (ctrl_i.clr) begin
      val_d  = cmmtf_pkg::SYM_W'(IDX);
      seen_d = 1'b0;
    end else if (ctrl_i.upd) begin
      if (shift) begin
        val_d = prev_val_i;
      end
      if (id_i == cmmtf_pkg::SYM_W'(IDX)) begin
        seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= cmmtf_pkg::SYM_W'(IDX);
      seen_q <= 1'b0;
    end else begin
      val_q  <= val_d;
      seen_q <= seen_d;
    end
  end

  assign val_o = val_q;

  // Drive the entry onto the lookup bus when addressed
  assign rd_o = (ctrl_i.sym == cmmtf_pkg::SYM_W'(IDX)) ? val_q : '0;

  // Completeness chain: ids above the maximum do not count
  assign ok_o = ok_i & (seen_q | ({1'b0, max_i} < cmmtf_pkg::CNT_W'(IDX)));

endmodule

// ----- src/cmmtf_out_stage.sv -----
`timescale 1ns / 1ps

// Output register: holds one result item until the sink takes it.
module cmmtf_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  cmmtf_pkg::cmmtf_result_t       res_i,
  output logic                           free_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cmmtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  logic                     valid_q;
  cmmtf_pkg::cmmtf_result_t res_q;

  assign free_o = ~valid_q | m_axis_tready;

  // Valid flag: set on load, drop once the item is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = res_q.is_last;
  assign m_axis_tdata  = {cmmtf_pkg::OUT_PAD_W'(0), res_q.map_complete,
                          res_q.num_clusters, res_q.cluster_id};

endmodule

// ----- src/cmmtf_checker.sv -----
`timescale 1ns / 1ps

`include "context_map_mtf_decode_check_defines.svh"

// Port-level checks on the context map decoder.
module cmmtf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [cmmtf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                              m_axis_tlast
);

  // Count and completeness only on the last item of a map
  `CMMTF_ASSERT_IMPL(a_mid_map_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[17:8] == 10'd0, "count or complete set on a non-last item")

  // Cluster count covers the id of the last item
  `CMMTF_ASSERT_IMPL(a_count_covers_id, m_axis_tvalid && m_axis_tlast, m_axis_tdata[16:8] > {1'b0, m_axis_tdata[7:0]}, "cluster count not above last id")

  // Padding stays zero
  `CMMTF_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:18] == 6'd0, "nonzero pad bits")

  // An accepted item blocks the input for its result cycle
  `CMMTF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

  // A stalled result holds
  `CMMTF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

endmodule

bind context_map_mtf_decode_check cmmtf_checker u_cmmtf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- sim/context_map_mtf_decode_check_monitor.sv -----
`timescale 1ns / 1ps

// Watch both streams and the mode register, predict every cluster id and map
// summary, and compare each delivered item with the oldest prediction.
module context_map_mtf_decode_check_monitor
  import cmmtf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // symbol[7:0]
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cluster_id[7:0], num_clusters[16:8], map_complete[17], pad[23:18]
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tlast,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int MAX_REPORTS = 10;

  // Predicted decoder state
  logic [SYM_W-1:0] mtf_table [TABLE_SIZE];
  logic             cluster_seen [TABLE_SIZE];
  logic [SYM_W-1:0] top_cluster;
  logic [CNT_W-1:0] distinct_ids;
  logic             mtf_mode;

  cmmtf_result_t    expected_q[$];
  int               fails;
  int               results_seen;

  // Return table, presence flags, maximum and distinct count to reset image
  function automatic void restore_identity_map();
    for (int k = 0; k < TABLE_SIZE; k++) begin
      mtf_table[k]    = SYM_W'(k);
      cluster_seen[k] = 1'b0;
    end
    top_cluster  = '0;
    distinct_ids = '0;
  endfunction

  // Decode one map entry and update the predicted state
  function automatic cmmtf_result_t decode_map_entry(logic [SYM_W-1:0] sym_in,
                                                     logic last_in);
    cmmtf_result_t    res;
    int               idx;
    logic [SYM_W-1:0] id;
    logic [CNT_W-1:0] count;
    idx = (sym_in > TABLE_SIZE - 1) ? TABLE_SIZE - 1 : int'(sym_in);
    if (mtf_mode) begin
      id = mtf_table[idx];
      for (int i = idx; i > 0; i--) begin
        mtf_table[i] = mtf_table[i-1];
      end
      mtf_table[0] = id;
    end else begin
      id = SYM_W'(idx);
    end
    if (!cluster_seen[id]) begin
      cluster_seen[id] = 1'b1;
      distinct_ids     = distinct_ids + 1'b1;
    end
    if (id > top_cluster) begin
      top_cluster = id;
    end
    res            = '0;
    res.cluster_id = id;
    res.is_last    = last_in;
    if (last_in) begin
      count            = {1'b0, top_cluster} + 1'b1;
      res.num_clusters = count;
      res.map_complete = (distinct_ids == count);
      restore_identity_map();
    end
    return res;
  endfunction

  // Track accepted items, compare delivered results, follow the mode register
  always @(posedge clk_i or negedge rst_ni) begin : track
    cmmtf_result_t got;
    cmmtf_result_t want;
    if (!rst_ni) begin
      restore_identity_map();
      mtf_mode = 1'b1;
      expected_q.delete();
      fails        = 0;
      results_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.cluster_id   = m_axis_tdata[SYM_W-1:0];
        got.num_clusters = m_axis_tdata[SYM_W+CNT_W-1:SYM_W];
        got.map_complete = m_axis_tdata[SYM_W+CNT_W];
        got.is_last      = m_axis_tlast;
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS) begin
            $display("result %0d arrived with no item pending: id=%0d last=%0b",
                     results_seen, got.cluster_id, got.is_last);
          end
        end else begin
          want = expected_q.pop_front();
          if (got.cluster_id !== want.cluster_id || got.is_last !== want.is_last ||
              got.num_clusters !== want.num_clusters ||
              got.map_complete !== want.map_complete) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
              $display("result %0d mismatch: expected id=%0d last=%0b count=%0d done=%0b",
                       results_seen, want.cluster_id, want.is_last,
                       want.num_clusters, want.map_complete);
              $display("  actual id=%0d last=%0b count=%0d done=%0b",
                       got.cluster_id, got.is_last, got.num_clusters,
                       got.map_complete);
            end
          end
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(decode_map_entry(s_axis_tdata[SYM_W-1:0], s_axis_tlast));
      end
      // a mode write takes effect from the next item on
      if (cfg_we_i) begin
        mtf_mode = cfg_wdata_i;
      end
      fail_count_o <= fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

// ----- sim/context_map_mtf_decode_check_test.sv -----
`timescale 1ns / 1ps

module context_map_mtf_decode_check_test;
  import cmmtf_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    MAP_WIDE,
    MAP_NARROW,
    MAP_PERM,
    MAP_NOISE
  } map_shape_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // symbol[7:0]
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // cluster_id[7:0], num_clusters[16:8], map_complete[17], pad[23:18]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  int fail_count;
  int pending;
  int items_sent;
  int burst_left;
  int rx_hold;

  context_map_mtf_decode_check DUT (.*);

  context_map_mtf_decode_check_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side in runs of random length, mostly ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= 0;
    end else if (rx_hold == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        rx_hold       <= $urandom_range(1, 40);
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold       <= $urandom_range(1, 6);
      end
    end else begin
      rx_hold <= rx_hold - 1;
    end
  end

  // Offer one map entry and hold it until taken; pause between bursts
  task automatic send_entry(input logic [SYM_W-1:0] sym, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                : $urandom_range(0, 24);
    end
  endtask

  // Drain all results, let the block settle, then write the mode register
  task automatic drain_and_set_mode(input logic mode);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Send one context map; an open map leaves its final entry unflagged, a noise map flags entries at random
  task automatic send_map(input map_shape_e shape, input int len, input bit close);
    int               perm [TABLE_SIZE];
    int               j;
    int               t;
    int               span;
    logic [SYM_W-1:0] sym;
    logic             last;
    for (int k = 0; k < len; k++) begin
      perm[k] = k;
    end
    for (int k = len - 1; k > 0; k--) begin
      j       = $urandom_range(0, k);
      t       = perm[k];
      perm[k] = perm[j];
      perm[j] = t;
    end
    span = $urandom_range(0, 7);
    for (int k = 0; k < len; k++) begin
      case (shape)
        MAP_NARROW: sym = SYM_W'($urandom_range(0, span));
        MAP_PERM:   sym = SYM_W'(perm[k]);
        default:    sym = SYM_W'($urandom_range(0, TABLE_SIZE - 1));
      endcase
      if (shape == MAP_NOISE) begin
        last = ($urandom_range(0, 3) == 0);
      end else begin
        last = close && (k == len - 1);
      end
      send_entry(sym, last);
    end
  endtask

  // Hard stop for a hung run
  initial begin
    #2000000;
    $display("context_map_mtf_decode_check test failed");
    $finish;
  end

  initial begin
    int         pick;
    map_shape_e shape;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    items_sent = 0;
    burst_left = $urandom_range(0, 24);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // MTF mode from reset: index zero, top index, repeated front picks
    send_entry(8'd0, 1'b0);
    send_entry(8'd255, 1'b0);
    send_entry(8'd1, 1'b0);
    send_entry(8'd0, 1'b0);
    send_entry(8'd2, 1'b1);

    // Pass-through: complete map, single top id, single id zero
    drain_and_set_mode(1'b0);
    send_entry(8'd0, 1'b0);
    send_entry(8'd1, 1'b0);
    send_entry(8'd2, 1'b0);
    send_entry(8'd3, 1'b1);
    send_entry(8'd255, 1'b1);
    send_entry(8'd0, 1'b1);
    send_entry(8'd7, 1'b0);
    send_entry(8'd5, 1'b0);

    // Switch back to MTF in the middle of that map
    drain_and_set_mode(1'b1);
    send_entry(8'd3, 1'b0);
    send_entry(8'd0, 1'b0);
    send_entry(8'd255, 1'b1);

    // Every id once in pass-through: the largest complete map
    drain_and_set_mode(1'b0);
    send_map(MAP_PERM, TABLE_SIZE, 1'b1);

    // Random phases of maps, each phase under a random mode
    while (items_sent < ITEM_TARGET) begin
      drain_and_set_mode($urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          shape = MAP_WIDE;
        end else if (pick < 7) begin
          shape = MAP_NARROW;
        end else if (pick < 9) begin
          shape = MAP_PERM;
        end else begin
          shape = MAP_NOISE;
        end
        send_map(shape, $urandom_range(1, 24), $urandom_range(0, 7) != 0);
      end
    end

    // Wait out the last results
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("context_map_mtf_decode_check test passed");
    end else begin
      $display("context_map_mtf_decode_check test failed");
    end
    $finish;
  end

endmodule
